// ===== rtl/ntc_pkg.sv =====
// shared types, type codes and helper functions of the numeric type converter
package ntc_pkg;

  localparam logic [2:0] TY_BYTE = 3'd0;
  localparam logic [2:0] TY_HALF = 3'd1;
  localparam logic [2:0] TY_FULL = 3'd2;
  localparam logic [2:0] TY_SING = 3'd3;
  localparam logic [2:0] TY_DOUB = 3'd4;
  localparam logic [2:0] TY_COMP = 3'd5;

  localparam logic [0:0] REG_SRC_TYPE = 1'b0;
  localparam logic [0:0] REG_DST_TYPE = 1'b1;

  typedef struct packed {
    logic [2:0] src_type;
    logic [2:0] dst_type;
  } cfg_t;

  // after unpack and leading zero count
  typedef struct packed {
    logic               byp;
    logic [63:0]        byp_val;
    logic               byp_err;
    logic               sgn;
    logic [52:0]        mant;
    logic signed [11:0] exp;
    logic [5:0]         lz;
    logic               last;
  } s1_t;

  // after normalization
  typedef struct packed {
    logic               byp;
    logic [63:0]        byp_val;
    logic               byp_err;
    logic               sgn;
    logic [52:0]        nm;
    logic signed [11:0] e;
    logic               last;
  } s2_t;

  // after alignment shift
  typedef struct packed {
    logic               byp;
    logic [63:0]        byp_val;
    logic               byp_err;
    logic               sgn;
    logic [52:0]        q;
    logic               guard;
    logic               sticky;
    logic signed [11:0] ep;
    logic               huge;
    logic               last;
  } s3_t;

  function automatic logic [63:0] type_mask(logic [2:0] t);
    logic [63:0] m;
    case (t)
      TY_BYTE: m = 64'h0000_0000_0000_00FF;
      TY_HALF: m = 64'h0000_0000_0000_FFFF;
      TY_FULL, TY_SING: m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

  // saturation value of an integer type, by sign
  function automatic logic [63:0] sat_val(logic [2:0] t, logic neg);
    logic [63:0] v;
    case (t)
      TY_BYTE: v = neg ? 64'h0 : 64'hFF;
      TY_HALF: v = neg ? 64'h8000 : 64'h7FFF;
      default: v = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ntc_if.sv =====
// stream interfaces of the converter: input element and result element
interface ntc_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] src_bits;
  logic        last_in;
  modport source (output valid, output src_bits, output last_in, input ready);
  modport sink (input valid, input src_bits, input last_in, output ready);
endinterface

interface ntc_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] dst_bits;
  logic        range_error;
  logic        last_out;
  modport source (output valid, output dst_bits, output range_error, output last_out,
                  input ready);
  modport sink (input valid, input dst_bits, input range_error, input last_out,
                output ready);
endinterface

// ===== rtl/ntc_unpack.sv =====
// stage one: operand unpack, special cases and leading zero count
module ntc_unpack (
  input  logic          clk,
  input  logic          rst_n,
  input  ntc_pkg::cfg_t cfg,
  ntc_in_if.sink        in_ch,
  output logic          dn_valid,
  input  logic          dn_ready,
  output ntc_pkg::s1_t  dn_data
);
  import ntc_pkg::*;

  function automatic logic [5:0] lead_zeros(logic [52:0] m);
    logic [5:0] c;
    c = 6'd0;
    for (int i = 0; i < 53; i++) begin
      if (m[i]) c = 6'(52 - i);
    end
    return c;
  endfunction

  logic        v_r;
  s1_t         d_r, d_nxt;
  logic [2:0]  st, dt;
  logic [63:0] src, sv, mag;
  logic [10:0] ex;
  logic [51:0] frac;
  logic        s_dbl, d_dbl, e_max, e_zero, f_zero;

  always_comb begin
    st    = cfg.src_type;
    dt    = cfg.dst_type;
    src   = in_ch.src_bits;
    s_dbl = (st == TY_DOUB);
    d_dbl = (dt == TY_DOUB);
    sv    = 64'd0;
    mag   = 64'd0;
    if (s_dbl) begin
      ex   = src[62:52];
      frac = src[51:0];
    end else begin
      ex   = {3'd0, src[30:23]};
      frac = {29'd0, src[22:0]};
    end
    e_max  = s_dbl ? (ex == 11'h7FF) : (ex[7:0] == 8'hFF);
    e_zero = (ex == 11'd0);
    f_zero = (frac == 52'd0);

    d_nxt         = '0;
    d_nxt.byp     = 1'b1;
    d_nxt.last    = in_ch.last_in;
    if (st > TY_COMP || dt > TY_COMP) begin
      d_nxt.byp_val = 64'd0;
    end else if (st == dt) begin
      d_nxt.byp_val = src & type_mask(st);
    end else if (st <= TY_FULL) begin
      case (st)
        TY_BYTE: sv = {56'd0, src[7:0]};
        TY_HALF: sv = {{48{src[15]}}, src[15:0]};
        default: sv = {{32{src[31]}}, src[31:0]};
      endcase
      if (dt <= TY_FULL) begin
        d_nxt.byp_val = sv & type_mask(dt);
      end else if (sv != 64'd0) begin
        d_nxt.byp  = 1'b0;
        d_nxt.sgn  = sv[63];
        mag        = sv[63] ? (64'd0 - sv) : sv;
        d_nxt.mant = {21'd0, mag[31:0]};
        d_nxt.exp  = 12'sd0;
      end
    end else begin
      d_nxt.sgn = s_dbl ? src[63] : src[31];
      if (dt <= TY_FULL) begin
        if (e_max && !f_zero) begin
          d_nxt.byp_err = 1'b1;
        end else if (e_max) begin
          d_nxt.byp_err = 1'b1;
          d_nxt.byp_val = sat_val(dt, d_nxt.sgn);
        end else if (!(e_zero && f_zero)) begin
          d_nxt.byp = 1'b0;
        end
      end else if (s_dbl == d_dbl) begin
        d_nxt.byp_val = {32'd0, src[31:0]};
      end else if (d_dbl) begin
        // single to double
        if (e_max && !f_zero) begin
          d_nxt.byp_val = {d_nxt.sgn, 11'h7FF, frac[22:0] | 23'h40_0000, 29'd0};
        end else if (e_max) begin
          d_nxt.byp_val = {d_nxt.sgn, 11'h7FF, 52'd0};
        end else if (e_zero && f_zero) begin
          d_nxt.byp_val = {d_nxt.sgn, 63'd0};
        end else begin
          d_nxt.byp = 1'b0;
        end
      end else begin
        // double to single
        if (e_max && !f_zero) begin
          d_nxt.byp_val = {32'd0, d_nxt.sgn, 8'hFF, 1'b1, frac[50:29]};
        end else if (e_max) begin
          d_nxt.byp_val = {32'd0, d_nxt.sgn, 8'hFF, 23'd0};
        end else if (e_zero && f_zero) begin
          d_nxt.byp_val = {32'd0, d_nxt.sgn, 31'd0};
        end else begin
          d_nxt.byp = 1'b0;
        end
      end
      if (s_dbl) begin
        d_nxt.mant = {!e_zero, frac};
        d_nxt.exp  = e_zero ? -12'sd1074 : ($signed({1'b0, ex}) - 12'sd1075);
      end else begin
        d_nxt.mant = {29'd0, !e_zero, frac[22:0]};
        d_nxt.exp  = e_zero ? -12'sd149 : ($signed({4'd0, ex[7:0]}) - 12'sd150);
      end
    end
    d_nxt.lz = lead_zeros(d_nxt.mant);
  end

  assign in_ch.ready = !v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ch.ready) begin
      v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      d_r <= d_nxt;
    end
  end

  assign dn_valid = v_r;
  assign dn_data  = d_r;
endmodule

// ===== rtl/ntc_norm.sv =====
// stages two and three: normalizing shift, then alignment shift with guard and sticky
module ntc_norm (
  input  logic          clk,
  input  logic          rst_n,
  input  ntc_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  ntc_pkg::s1_t  up_data,
  output logic          dn_valid,
  input  logic          dn_ready,
  output ntc_pkg::s3_t  dn_data
);
  import ntc_pkg::*;

  logic               v2_r, v3_r, rdy2, rdy3;
  s2_t                d2_r, d2_nxt;
  s3_t                d3_r, d3_nxt;
  logic signed [12:0] e13, emin13, s13;
  logic [5:0]         sh;
  logic [52:0]        gtmp, lowmask;
  logic               d_dbl;

  // normalize so the leading one sits at bit 52
  always_comb begin
    d2_nxt.byp     = up_data.byp;
    d2_nxt.byp_val = up_data.byp_val;
    d2_nxt.byp_err = up_data.byp_err;
    d2_nxt.sgn     = up_data.sgn;
    d2_nxt.last    = up_data.last;
    d2_nxt.nm      = up_data.mant << up_data.lz;
    d2_nxt.e       = up_data.exp + 12'sd52 - $signed({6'd0, up_data.lz});
  end

  // right shift toward the target precision or the integer point
  always_comb begin
    d_dbl  = (cfg.dst_type == TY_DOUB);
    e13    = {d2_r.e[11], d2_r.e};
    emin13 = d_dbl ? -13'sd1022 : -13'sd126;
    d3_nxt.byp     = d2_r.byp;
    d3_nxt.byp_val = d2_r.byp_val;
    d3_nxt.byp_err = d2_r.byp_err;
    d3_nxt.sgn     = d2_r.sgn;
    d3_nxt.last    = d2_r.last;
    d3_nxt.huge    = 1'b0;
    d3_nxt.ep      = d2_r.e;
    if (cfg.dst_type <= TY_FULL) begin
      d3_nxt.huge = (e13 > 13'sd31);
      s13 = (e13 < 13'sd0) ? 13'sd55 : (13'sd52 - e13);
    end else if (e13 < emin13) begin
      d3_nxt.ep = emin13[11:0];
      s13 = (d_dbl ? 13'sd0 : 13'sd29) + (emin13 - e13);
    end else begin
      s13 = d_dbl ? 13'sd0 : 13'sd29;
    end
    if (s13 > 13'sd55) begin
      sh = 6'd55;
    end else if (s13 < 13'sd0) begin
      sh = 6'd0;
    end else begin
      sh = s13[5:0];
    end
    d3_nxt.q      = d2_r.nm >> sh;
    gtmp          = d2_r.nm >> (sh - 6'd1);
    lowmask       = (sh < 6'd2) ? 53'd0 : ((53'd1 << (sh - 6'd1)) - 53'd1);
    d3_nxt.guard  = (sh != 6'd0) && gtmp[0];
    d3_nxt.sticky = |(d2_r.nm & lowmask);
  end

  assign rdy3     = !v3_r || dn_ready;
  assign rdy2     = !v2_r || rdy3;
  assign up_ready = rdy2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy2) v2_r <= up_valid;
      if (rdy3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && up_valid) d2_r <= d2_nxt;
    if (rdy3 && v2_r) d3_r <= d3_nxt;
  end

  assign dn_valid = v3_r;
  assign dn_data  = d3_r;
endmodule

// ===== rtl/ntc_pack.sv =====
// stage four: rounding, saturation, packing and the output register
module ntc_pack (
  input  logic          clk,
  input  logic          rst_n,
  input  ntc_pkg::cfg_t cfg,
  input  logic          up_valid,
  output logic          up_ready,
  input  ntc_pkg::s3_t  up_data,
  ntc_out_if.source     out_ch
);
  import ntc_pkg::*;

  logic               v_r;
  logic [63:0]        res_r, res_nxt;
  logic               err_r, err_nxt, last_r;
  logic [2:0]         dt;
  logic signed [33:0] iv, lo, hi;
  logic [53:0]        qr, qn;
  logic               rup, ovf;
  logic signed [12:0] en, biased;

  always_comb begin
    dt      = cfg.dst_type;
    res_nxt = up_data.byp_val;
    err_nxt = up_data.byp_err;
    iv      = up_data.sgn ? -$signed({2'b0, up_data.q[31:0]})
                          : $signed({2'b0, up_data.q[31:0]});
    case (dt)
      TY_BYTE: begin lo = 34'sd0;          hi = 34'sd255;        end
      TY_HALF: begin lo = -34'sd32768;      hi = 34'sd32767;      end
      default: begin lo = -34'sd2147483648; hi = 34'sd2147483647; end
    endcase
    rup    = up_data.guard && (up_data.sticky || up_data.q[0]);
    qr     = {1'b0, up_data.q} + {53'd0, rup};
    ovf    = (dt == TY_DOUB) ? qr[53] : qr[24];
    qn     = ovf ? (qr >> 1) : qr;
    en     = {up_data.ep[11], up_data.ep} + {12'd0, ovf};
    biased = en + ((dt == TY_DOUB) ? 13'sd1023 : 13'sd127);
    if (!up_data.byp) begin
      if (dt <= TY_FULL) begin
        if (up_data.huge) begin
          err_nxt = 1'b1;
          res_nxt = sat_val(dt, up_data.sgn);
        end else if (iv < lo) begin
          err_nxt = 1'b1;
          res_nxt = 64'(lo) & type_mask(dt);
        end else if (iv > hi) begin
          err_nxt = 1'b1;
          res_nxt = 64'(hi);
        end else begin
          res_nxt = {{30{iv[33]}}, iv} & type_mask(dt);
        end
      end else if (dt == TY_DOUB) begin
        if (!qn[52]) begin
          res_nxt = {up_data.sgn, 11'd0, qn[51:0]};
        end else if (biased >= 13'sd2047) begin
          res_nxt = {up_data.sgn, 11'h7FF, 52'd0};
        end else begin
          res_nxt = {up_data.sgn, biased[10:0], qn[51:0]};
        end
      end else begin
        if (!qn[23]) begin
          res_nxt = {32'd0, up_data.sgn, 8'd0, qn[22:0]};
        end else if (biased >= 13'sd255) begin
          res_nxt = {32'd0, up_data.sgn, 8'hFF, 23'd0};
        end else begin
          res_nxt = {32'd0, up_data.sgn, biased[7:0], qn[22:0]};
        end
      end
    end
  end

  assign up_ready = !v_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res_r  <= res_nxt;
      err_r  <= err_nxt;
      last_r <= up_data.last;
    end
  end

  assign out_ch.valid       = v_r;
  assign out_ch.dst_bits    = res_r;
  assign out_ch.range_error = err_r;
  assign out_ch.last_out    = last_r;
endmodule

// ===== rtl/numeric_type_converter_unit.sv =====
// top level of the numeric type converter: configuration registers and the four-stage pipeline
// Converts one element per clock, while the output is not stalled, between byte, half
// (16-bit signed), full (32-bit signed), single, double and complex (two singles, real part
// in bits 31:0). Each element passes four register stages, in this order: unpack and
// leading zero count, normalizing shift, alignment shift, then rounding and saturation. A
// new request may enter every cycle while the output is not stalled; each stage holds its
// item while the stage after it is full, so a stalled output backs up the pipeline. Source
// and destination types are written over the APB port at byte addresses 0 and 4; the user
// must write them only while the pipeline is empty, which the block itself does not enforce.
module numeric_type_converter_unit (
  input  logic        clk,
  input  logic        rst_n,
  ntc_in_if.sink      in_ch,
  ntc_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ntc_pkg::*;

  // configuration registers
  logic [2:0] src_type_r, dst_type_r;
  cfg_t       cfg;
  logic       wr_en;

  // stage links
  logic v1, r1, v3, r3;
  s1_t  d1;
  s3_t  d3;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;

  // register select by address bit two; low bits of the address are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_type_r <= TY_BYTE;
      dst_type_r <= TY_HALF;
    end else if (wr_en) begin
      unique case (cfg_paddr[2])
        REG_SRC_TYPE: src_type_r <= cfg_pwdata[2:0];
        REG_DST_TYPE: dst_type_r <= cfg_pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      REG_SRC_TYPE: cfg_prdata = {29'd0, src_type_r};
      REG_DST_TYPE: cfg_prdata = {29'd0, dst_type_r};
      default:      cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.src_type = src_type_r;
  assign cfg.dst_type = dst_type_r;

  // stage one: unpack, special values, leading zeros
  ntc_unpack u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_ch    (in_ch),
    .dn_valid (v1),
    .dn_ready (r1),
    .dn_data  (d1)
  );

  // stages two and three: normalize and align
  ntc_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (v1),
    .up_ready (r1),
    .up_data  (d1),
    .dn_valid (v3),
    .dn_ready (r3),
    .dn_data  (d3)
  );

  // stage four: round, saturate, pack into the result register
  ntc_pack u_pack (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (v3),
    .up_ready (r3),
    .up_data  (d3),
    .out_ch   (out_ch)
  );

  // range errors come only from conversions of floating point sources into integer types
  a_err_int_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.range_error |-> dst_type_r <= TY_FULL && src_type_r >= TY_SING)
    else $error("range error on a conversion that cannot saturate");

  // byte results have nothing above bit seven
  a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && dst_type_r == TY_BYTE |-> out_ch.dst_bits[63:8] == 56'd0)
    else $error("byte result with high bits set");

  // single and complex results keep the upper word zero unless passed through as complex
  a_single_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (dst_type_r == TY_SING || (dst_type_r == TY_COMP && src_type_r != TY_COMP))
    |-> out_ch.dst_bits[63:32] == 32'd0)
    else $error("single result with upper word set");

  // unused type codes give a zero result
  a_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && (src_type_r > TY_COMP || dst_type_r > TY_COMP)
    |-> out_ch.dst_bits == 64'd0 && !out_ch.range_error)
    else $error("unused type code gave a nonzero result");
endmodule
